FILE: rtl/qslerp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qslerp_pkg
// Types, formats and constants shared by the quaternion slerp pipeline.
// ----------------------------------------------------------------------------
package qslerp_pkg;

    localparam int FRAC_BITS     = 14;
    localparam int CORDIC_STAGES = 16;

    localparam int COMP_W = 16;
    localparam int FRAC_W = 17;
    localparam int THR_W  = 15;
    localparam int PATH_W = 2;

    localparam logic [THR_W-1:0]  THR_RESET = 15'd16382;
    localparam logic [FRAC_W-1:0] T_ONE     = 17'd65536;
    localparam int                T_SHIFT   = 16;

    localparam logic [PATH_W-1:0] PATH_PASS   = 2'd0;
    localparam logic [PATH_W-1:0] PATH_LINEAR = 2'd1;
    localparam logic [PATH_W-1:0] PATH_SPHERE = 2'd2;

    // dot product and its Q30 form
    localparam int PROD_W  = 2 * COMP_W;
    localparam int DOT_W   = PROD_W + 2;
    localparam int D30_W   = 32;
    localparam int MAG_W   = 31;
    localparam int D30_LSH = (30 - 2 * FRAC_BITS) > 0 ? (30 - 2 * FRAC_BITS) : 0;
    localparam int D30_RSH = (2 * FRAC_BITS - 30) > 0 ? (2 * FRAC_BITS - 30) : 0;

    // square root of a Q60 value
    localparam int SQ_W      = 61;
    localparam int ROOT_W    = 31;
    localparam int ISQ_STEPS = 31;
    localparam int ISQ_LAT   = ISQ_STEPS + 1;

    // cordic datapath
    localparam int CW      = 34;
    localparam int ANG_W   = 32;
    localparam int VEC_LAT = CORDIC_STAGES + 2;
    localparam int ROT_LAT = CORDIC_STAGES + 1;

    localparam logic [ANG_W-1:0]    HALF_PI   = 32'd1686629713;
    localparam logic [ANG_W-1:0]    FULL_PI   = 32'd3373259426;
    localparam logic signed [CW-1:0] HALF_PI_Z = CW'(HALF_PI);
    localparam logic signed [CW-1:0] FULL_PI_Z = CW'(FULL_PI);
    localparam logic signed [CW-1:0] ONE_Z     = CW'(1) <<< 30;

    // weight divider
    localparam int NUM_W     = 48;
    localparam int DEN_W     = 32;
    localparam int DIV_STEPS = NUM_W;
    localparam int DIV_LAT   = DIV_STEPS + 2;
    localparam int WT_W      = 33;
    localparam logic [NUM_W-1:0] WEIGHT_LIMIT = NUM_W'(1) << 31;

    // weighted sum
    localparam int WP_W = WT_W + COMP_W;
    localparam int PS_W = WP_W + 1;

    typedef struct packed {
        logic signed [COMP_W-1:0] first_w;
        logic signed [COMP_W-1:0] first_x;
        logic signed [COMP_W-1:0] first_y;
        logic signed [COMP_W-1:0] first_z;
        logic signed [COMP_W-1:0] second_w;
        logic signed [COMP_W-1:0] second_x;
        logic signed [COMP_W-1:0] second_y;
        logic signed [COMP_W-1:0] second_z;
        logic [FRAC_W-1:0]        fraction;
    } in_t;

    typedef struct packed {
        logic signed [COMP_W-1:0] out_w;
        logic signed [COMP_W-1:0] out_x;
        logic signed [COMP_W-1:0] out_y;
        logic signed [COMP_W-1:0] out_z;
        logic [PATH_W-1:0]        path_taken;
    } out_t;

    typedef struct packed {
        logic [3:0][COMP_W-1:0]  a;
        logic [3:0][COMP_W-1:0]  b;
        logic [FRAC_W-1:0]       t;
        logic signed [D30_W-1:0] d30;
        logic                    zero;
        logic                    sph;
        logic                    s_ok;
        logic                    ys_ok;
    } side_t;

    // atan(2^-idx) in Q30, rounded
    function automatic logic signed [CW-1:0] atan_q30(input int idx);
        logic signed [CW-1:0] v;
        unique case (idx)
            0: v = CW'(843314857);
            1: v = CW'(497837829);
            2: v = CW'(263043837);
            3: v = CW'(133525159);
            4: v = CW'(67021687);
            5: v = CW'(33543516);
            6: v = CW'(16775851);
            7: v = CW'(8388437);
            8: v = CW'(4194283);
            9: v = CW'(2097149);
            default: v = (idx <= 30) ? (CW'(1) <<< (30 - idx)) : '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/qslerp_isqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qslerp_isqrt
// Pipelined floor square root of 2^60 - dsq, one result bit per stage.
// ----------------------------------------------------------------------------
module qslerp_isqrt (
    input  logic                           aclk,
    input  logic                           en,
    input  logic [qslerp_pkg::SQ_W-1:0]    dsq,
    output logic [qslerp_pkg::ROOT_W-1:0]  root
);
    import qslerp_pkg::*;

    localparam int ACC_W = SQ_W + 1;

    logic [SQ_W-1:0]  v_reg [ISQ_STEPS+1];
    logic [ACC_W-1:0] r_reg [ISQ_STEPS+1];

    always_ff @(posedge aclk) begin
        if (en) begin
            v_reg[0] <= {1'b1, {(SQ_W-1){1'b0}}} - dsq;
            r_reg[0] <= '0;
        end
    end

    for (genvar i = 1; i <= ISQ_STEPS; i++) begin : g_step
        localparam logic [ACC_W-1:0] STEP_BIT = ACC_W'(1) << (2 * (ISQ_STEPS - i));
        logic [ACC_W-1:0] trial;
        assign trial = r_reg[i-1] + STEP_BIT;

        always_ff @(posedge aclk) begin
            if (en) begin
                if ({1'b0, v_reg[i-1]} >= trial) begin
                    v_reg[i] <= v_reg[i-1] - trial[SQ_W-1:0];
                    r_reg[i] <= (r_reg[i-1] >> 1) + STEP_BIT;
                end else begin
                    v_reg[i] <= v_reg[i-1];
                    r_reg[i] <= r_reg[i-1] >> 1;
                end
            end
        end
    end

    assign root = r_reg[ISQ_STEPS][ROOT_W-1:0];

endmodule
`default_nettype wire

FILE: rtl/qslerp_cordic_vec.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qslerp_cordic_vec
// Pipelined vectoring cordic: angle of (d, s) in Q30 radians, 0 to pi.
// ----------------------------------------------------------------------------
module qslerp_cordic_vec (
    input  logic                                 aclk,
    input  logic                                 en,
    input  logic signed [qslerp_pkg::D30_W-1:0]  d30,
    input  logic [qslerp_pkg::ROOT_W-1:0]        s30,
    output logic [qslerp_pkg::ANG_W-1:0]         theta
);
    import qslerp_pkg::*;

    logic signed [CW-1:0] x_reg [CORDIC_STAGES+1];
    logic signed [CW-1:0] y_reg [CORDIC_STAGES+1];
    logic signed [CW-1:0] z_reg [CORDIC_STAGES+1];
    logic [ANG_W-1:0]     theta_reg;
    logic signed [CW-1:0] xi;
    logic signed [CW-1:0] yi;

    assign xi = CW'(d30);
    assign yi = CW'(s30);

    // left half plane: turn by -pi/2 first
    always_ff @(posedge aclk) begin
        if (en) begin
            if (xi < 0) begin
                x_reg[0] <= yi;
                y_reg[0] <= -xi;
                z_reg[0] <= HALF_PI_Z;
            end else begin
                x_reg[0] <= xi;
                y_reg[0] <= yi;
                z_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 1; i <= CORDIC_STAGES; i++) begin : g_stage
        localparam logic signed [CW-1:0] ATAN = atan_q30(i - 1);

        always_ff @(posedge aclk) begin
            if (en) begin
                if (y_reg[i-1] > 0) begin
                    x_reg[i] <= x_reg[i-1] + (y_reg[i-1] >>> (i - 1));
                    y_reg[i] <= y_reg[i-1] - (x_reg[i-1] >>> (i - 1));
                    z_reg[i] <= z_reg[i-1] + ATAN;
                end else begin
                    x_reg[i] <= x_reg[i-1] - (y_reg[i-1] >>> (i - 1));
                    y_reg[i] <= y_reg[i-1] + (x_reg[i-1] >>> (i - 1));
                    z_reg[i] <= z_reg[i-1] - ATAN;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (z_reg[CORDIC_STAGES] < 0) begin
                theta_reg <= '0;
            end else if (z_reg[CORDIC_STAGES] > FULL_PI_Z) begin
                theta_reg <= FULL_PI;
            end else begin
                theta_reg <= z_reg[CORDIC_STAGES][ANG_W-1:0];
            end
        end
    end

    assign theta = theta_reg;

endmodule
`default_nettype wire

FILE: rtl/qslerp_cordic_rot.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qslerp_cordic_rot
// Pipelined rotation cordic: gain-scaled sine of an angle from 0 to pi.
// ----------------------------------------------------------------------------
module qslerp_cordic_rot (
    input  logic                              aclk,
    input  logic                              en,
    input  logic [qslerp_pkg::ANG_W-1:0]      phi,
    output logic signed [qslerp_pkg::CW-1:0]  sine
);
    import qslerp_pkg::*;

    logic signed [CW-1:0] x_reg [CORDIC_STAGES+1];
    logic signed [CW-1:0] y_reg [CORDIC_STAGES+1];
    logic signed [CW-1:0] z_reg [CORDIC_STAGES+1];

    // fold the second quadrant onto the first
    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0] <= ONE_Z;
            y_reg[0] <= '0;
            if (phi > HALF_PI) begin
                z_reg[0] <= CW'(FULL_PI - phi);
            end else begin
                z_reg[0] <= CW'(phi);
            end
        end
    end

    for (genvar i = 1; i <= CORDIC_STAGES; i++) begin : g_stage
        localparam logic signed [CW-1:0] ATAN = atan_q30(i - 1);

        always_ff @(posedge aclk) begin
            if (en) begin
                if (z_reg[i-1] >= 0) begin
                    x_reg[i] <= x_reg[i-1] - (y_reg[i-1] >>> (i - 1));
                    y_reg[i] <= y_reg[i-1] + (x_reg[i-1] >>> (i - 1));
                    z_reg[i] <= z_reg[i-1] - ATAN;
                end else begin
                    x_reg[i] <= x_reg[i-1] + (y_reg[i-1] >>> (i - 1));
                    y_reg[i] <= y_reg[i-1] - (x_reg[i-1] >>> (i - 1));
                    z_reg[i] <= z_reg[i-1] + ATAN;
                end
            end
        end
    end

    assign sine = y_reg[CORDIC_STAGES];

endmodule
`default_nettype wire

FILE: rtl/qslerp_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qslerp_div
// Pipelined restoring divider for one weight: (y * 2^16) / den, truncated
// toward zero and saturated to +/- 2^31.
// ----------------------------------------------------------------------------
module qslerp_div (
    input  logic                                aclk,
    input  logic                                en,
    input  logic signed [qslerp_pkg::CW-1:0]    num_y,
    input  logic signed [qslerp_pkg::CW-1:0]    den,
    output logic signed [qslerp_pkg::WT_W-1:0]  weight
);
    import qslerp_pkg::*;

    logic [NUM_W-1:0]     nq_reg  [DIV_STEPS+1];
    logic [DEN_W-1:0]     rem_reg [DIV_STEPS+1];
    logic [DEN_W-1:0]     den_reg [DIV_STEPS+1];
    logic                 neg_reg [DIV_STEPS+1];
    logic signed [WT_W-1:0] weight_reg;
    logic signed [CW-1:0] mag;
    logic [NUM_W-1:0]     q;
    logic [WT_W-1:0]      qs;

    assign mag = (num_y < 0) ? -num_y : num_y;

    always_ff @(posedge aclk) begin
        if (en) begin
            neg_reg[0] <= num_y < 0;
            nq_reg[0]  <= {mag[DEN_W-1:0], {T_SHIFT{1'b0}}};
            den_reg[0] <= den[DEN_W-1:0];
            rem_reg[0] <= '0;
        end
    end

    // numerator bits shift out at the top, quotient bits shift in at the bottom
    for (genvar i = 1; i <= DIV_STEPS; i++) begin : g_step
        logic [DEN_W:0] trial;
        logic           fits;
        assign trial = {rem_reg[i-1], nq_reg[i-1][NUM_W-1]};
        assign fits  = trial >= {1'b0, den_reg[i-1]};

        always_ff @(posedge aclk) begin
            if (en) begin
                if (fits) begin
                    rem_reg[i] <= DEN_W'(trial - {1'b0, den_reg[i-1]});
                end else begin
                    rem_reg[i] <= trial[DEN_W-1:0];
                end
                nq_reg[i]  <= {nq_reg[i-1][NUM_W-2:0], fits};
                den_reg[i] <= den_reg[i-1];
                neg_reg[i] <= neg_reg[i-1];
            end
        end
    end

    assign q  = nq_reg[DIV_STEPS];
    assign qs = (q > WEIGHT_LIMIT) ? WEIGHT_LIMIT[WT_W-1:0] : q[WT_W-1:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            weight_reg <= neg_reg[DIV_STEPS] ? -$signed(qs) : $signed(qs);
        end
    end

    assign weight = weight_reg;

endmodule
`default_nettype wire

FILE: rtl/quaternion_slerp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_slerp
// Spherical linear interpolation of two Q1.14 quaternions by a Q1.16 fraction.
// ----------------------------------------------------------------------------
// Fully pipelined: one item per cycle unless the result stalls. The depth comes
// from the 31-step square root, the vectoring and rotation cordic passes and
// the 48-step weight dividers, each one step per stage. A stalled result
// freezes the whole pipeline; nothing is dropped. near_threshold is written
// through cfg_wr_en/cfg_wr_data and should only change while the pipeline is
// empty.
module quaternion_slerp (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  qslerp_pkg::in_t                s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output qslerp_pkg::out_t               m_data,
    input  logic                           cfg_wr_en,
    input  logic [qslerp_pkg::THR_W-1:0]   cfg_wr_data
);
    import qslerp_pkg::*;

    localparam int I_SQ  = ISQ_LAT;
    localparam int I_TH  = I_SQ + VEC_LAT;
    localparam int I_PHI = I_TH + 1;
    localparam int I_Y   = I_PHI + ROT_LAT;
    localparam int I_K   = I_Y + DIV_LAT;

    logic                     adv;
    logic [THR_W-1:0]         thr_reg;
    logic                     m_valid_reg;
    out_t                     m_data_reg;

    // front stages
    side_t                    side_in;
    side_t                    side1_reg;
    side_t                    side2_reg;
    side_t                    side3_reg;
    side_t                    side3_next;
    logic [2:0]               vpre_reg;
    logic signed [PROD_W-1:0] p1_reg [4];
    logic signed [DOT_W-1:0]  dot2_reg;
    logic signed [63:0]       dwide;
    logic signed [63:0]       thr_wide;
    logic signed [D30_W-1:0]  d30_next;
    logic [MAG_W-1:0]         mag3;
    logic [SQ_W-1:0]          dsq_reg;

    // middle chain
    side_t                    side_reg [I_K+1];
    side_t                    sq_next;
    side_t                    ys_next;
    logic [I_K:0]             vmid_reg;
    logic [ROOT_W-1:0]        s30;
    logic [ANG_W-1:0]         theta;
    logic [ANG_W+FRAC_W-1:0]  mul0;
    logic [ANG_W+FRAC_W-1:0]  mul1;
    logic [ANG_W-1:0]         theta_reg;
    logic [ANG_W-1:0]         phi0_reg;
    logic [ANG_W-1:0]         phi1_reg;
    logic signed [CW-1:0]     ys;
    logic signed [CW-1:0]     y0;
    logic signed [CW-1:0]     y1;
    logic signed [WT_W-1:0]   k0;
    logic signed [WT_W-1:0]   k1;

    // weighting stages
    logic                     sphere;
    logic signed [WT_W-1:0]   wk0;
    logic signed [WT_W-1:0]   wk1;
    logic                     vf1_reg;
    logic [PATH_W-1:0]        path_f1_reg;
    logic [3:0][COMP_W-1:0]   pass_f1_reg;
    logic signed [WP_W-1:0]   prod0_reg [4];
    logic signed [WP_W-1:0]   prod1_reg [4];
    logic [3:0][COMP_W-1:0]   res;

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THR_RESET;
        end else if (cfg_wr_en) begin
            thr_reg <= cfg_wr_data;
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vpre_reg    <= '0;
            vmid_reg    <= '0;
            vf1_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            vpre_reg    <= {vpre_reg[1:0], s_valid};
            vmid_reg    <= {vmid_reg[I_K-1:0], vpre_reg[2]};
            vf1_reg     <= vmid_reg[I_K];
            m_valid_reg <= vf1_reg;
        end
    end

    always_comb begin
        side_in       = '0;
        side_in.a[0]  = s_data.first_w;
        side_in.a[1]  = s_data.first_x;
        side_in.a[2]  = s_data.first_y;
        side_in.a[3]  = s_data.first_z;
        side_in.b[0]  = s_data.second_w;
        side_in.b[1]  = s_data.second_x;
        side_in.b[2]  = s_data.second_y;
        side_in.b[3]  = s_data.second_z;
        side_in.t     = (s_data.fraction > T_ONE) ? T_ONE : s_data.fraction;
    end

    // stage 1: products, stage 2: dot sum
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int j = 0; j < 4; j++) begin
                p1_reg[j] <= $signed(side_in.a[j]) * $signed(side_in.b[j]);
            end
            side1_reg <= side_in;
            dot2_reg  <= DOT_W'(p1_reg[0]) + DOT_W'(p1_reg[1])
                       + DOT_W'(p1_reg[2]) + DOT_W'(p1_reg[3]);
            side2_reg <= side1_reg;
        end
    end

    // stage 3: Q30 conversion, clamp and path flags
    always_comb begin
        dwide    = (64'(dot2_reg) <<< D30_LSH) >>> D30_RSH;
        thr_wide = $signed(64'(thr_reg) << FRAC_BITS);
        if (dwide > 64'(ONE_Z)) begin
            d30_next = D30_W'(ONE_Z);
        end else if (dwide < -64'(ONE_Z)) begin
            d30_next = -D30_W'(ONE_Z);
        end else begin
            d30_next = dwide[D30_W-1:0];
        end
        side3_next      = side2_reg;
        side3_next.d30  = d30_next;
        side3_next.zero = dot2_reg == '0;
        side3_next.sph  = 64'(dot2_reg) <= thr_wide;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side3_reg <= side3_next;
        end
    end

    // stage 4: d squared; then the long chain follows the datapath units
    assign mag3 = (side3_reg.d30 < 0) ? MAG_W'(-side3_reg.d30) : MAG_W'(side3_reg.d30);

    always_comb begin
        sq_next       = side_reg[I_SQ];
        sq_next.s_ok  = s30 != '0;
        ys_next       = side_reg[I_Y];
        ys_next.ys_ok = ys > 0;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dsq_reg     <= mag3 * mag3;
            side_reg[0] <= side3_reg;
            for (int i = 1; i <= I_K; i++) begin
                if (i == I_SQ + 1) begin
                    side_reg[i] <= sq_next;
                end else if (i == I_Y + 1) begin
                    side_reg[i] <= ys_next;
                end else begin
                    side_reg[i] <= side_reg[i-1];
                end
            end
        end
    end

    qslerp_isqrt u_isqrt (
        .aclk (aclk),
        .en   (adv),
        .dsq  (dsq_reg),
        .root (s30)
    );

    qslerp_cordic_vec u_vec (
        .aclk  (aclk),
        .en    (adv),
        .d30   (side_reg[I_SQ].d30),
        .s30   (s30),
        .theta (theta)
    );

    // scale the angle by 1-t and t
    assign mul0 = theta * (T_ONE - side_reg[I_TH].t);
    assign mul1 = theta * side_reg[I_TH].t;

    always_ff @(posedge aclk) begin
        if (adv) begin
            theta_reg <= theta;
            phi0_reg  <= mul0[ANG_W+T_SHIFT-1:T_SHIFT];
            phi1_reg  <= mul1[ANG_W+T_SHIFT-1:T_SHIFT];
        end
    end

    qslerp_cordic_rot u_rot_th (
        .aclk (aclk),
        .en   (adv),
        .phi  (theta_reg),
        .sine (ys)
    );

    qslerp_cordic_rot u_rot_0 (
        .aclk (aclk),
        .en   (adv),
        .phi  (phi0_reg),
        .sine (y0)
    );

    qslerp_cordic_rot u_rot_1 (
        .aclk (aclk),
        .en   (adv),
        .phi  (phi1_reg),
        .sine (y1)
    );

    qslerp_div u_div_0 (
        .aclk   (aclk),
        .en     (adv),
        .num_y  (y0),
        .den    (ys),
        .weight (k0)
    );

    qslerp_div u_div_1 (
        .aclk   (aclk),
        .en     (adv),
        .num_y  (y1),
        .den    (ys),
        .weight (k1)
    );

    // weight selection and products
    assign sphere = !side_reg[I_K].zero && side_reg[I_K].sph
                 && side_reg[I_K].s_ok && side_reg[I_K].ys_ok;
    assign wk0 = sphere ? k0 : $signed(WT_W'(T_ONE - side_reg[I_K].t));
    assign wk1 = sphere ? k1 : $signed(WT_W'(side_reg[I_K].t));

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int j = 0; j < 4; j++) begin
                prod0_reg[j] <= wk0 * $signed(side_reg[I_K].a[j]);
                prod1_reg[j] <= wk1 * $signed(side_reg[I_K].b[j]);
            end
            pass_f1_reg <= side_reg[I_K].a;
            if (side_reg[I_K].zero) begin
                path_f1_reg <= PATH_PASS;
            end else if (sphere) begin
                path_f1_reg <= PATH_SPHERE;
            end else begin
                path_f1_reg <= PATH_LINEAR;
            end
        end
    end

    // round, shift and saturate
    always_comb begin
        logic signed [PS_W-1:0] sum;
        logic signed [PS_W-1:0] r;
        for (int j = 0; j < 4; j++) begin
            sum = PS_W'(prod0_reg[j]) + PS_W'(prod1_reg[j]) + PS_W'(32768);
            r   = sum >>> T_SHIFT;
            if (path_f1_reg == PATH_PASS) begin
                res[j] = pass_f1_reg[j];
            end else if (r > PS_W'(32767)) begin
                res[j] = 16'h7fff;
            end else if (r < -PS_W'(32768)) begin
                res[j] = 16'h8000;
            end else begin
                res[j] = r[COMP_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg.out_w      <= res[0];
            m_data_reg.out_x      <= res[1];
            m_data_reg.out_y      <= res[2];
            m_data_reg.out_z      <= res[3];
            m_data_reg.path_taken <= path_f1_reg;
        end
    end

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while result stalled");

    a_stall_keeps_item: assert property (@(posedge aclk) disable iff (!aresetn)
        vmid_reg[I_K] && !adv |=> vmid_reg[I_K])
        else $error("item lost in pipeline during stall");

endmodule
`default_nettype wire

FILE: sim/quaternion_slerp_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_slerp_tb
// Drives quaternion pairs and fractions into the slerp pipeline and computes
// each expected result with a bit-exact fixed-point model of its own. Results
// are compared in order, field by field, under random idling on both sides,
// one long result stall and several near_threshold settings.
// ----------------------------------------------------------------------------
module quaternion_slerp_tb;
    import qslerp_pkg::*;

    localparam int ITEMS_PER_PHASE = 360;
    localparam int NUM_PHASES      = 5;
    localparam int DRAIN_CYCLES    = 140;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int LONG_HOLD       = 600;
    localparam longint ONE_Q30     = 64'sd1 <<< 30;
    localparam longint WT_LIMIT    = 64'sd1 <<< 31;

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    in_t              s_data;
    logic             m_valid;
    logic             m_ready;
    out_t             m_data;
    logic             cfg_wr_en;
    logic [THR_W-1:0] cfg_wr_data;

    quaternion_slerp dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    in_t          pending_items[$];
    out_t         expected_slerp[$];
    logic [THR_W-1:0] thr_model;
    longint       atan_tab[CORDIC_STAGES];
    longint       half_pi_q;
    longint       full_pi_q;
    int           items_queued;
    int           items_taken;
    int           results_seen;
    int           taken_seen;
    int           mismatches;
    int           quiet_cycles;
    int           src_idle_pct;
    int           snk_idle_pct;
    int           hold_left;
    bit           long_hold_done;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // ---------------- fixed-point slerp model ----------------

    function automatic longint atan_recip_q61(longint unsigned n);
        longint unsigned p, nn, k;
        longint sum, term;
        p = (64'd1 << 61) / n;
        nn = n * n;
        sum = 0;
        k = 0;
        while (p != 0) begin
            term = longint'(p / (2 * k + 1));
            sum += k[0] ? -term : term;
            p /= nn;
            k++;
        end
        return sum;
    endfunction

    function automatic void build_angles();
        longint unsigned qpi, av;
        qpi = longint'(atan_recip_q61(2) + atan_recip_q61(3));
        atan_tab[0] = longint'((qpi + (64'd1 << 30)) >> 31);
        for (int i = 1; i < CORDIC_STAGES; i++) begin
            av = atan_recip_q61(64'd1 << i);
            atan_tab[i] = longint'((av + (64'd1 << 30)) >> 31);
        end
        half_pi_q = longint'((2 * qpi + (64'd1 << 30)) >> 31);
        full_pi_q = longint'((4 * qpi + (64'd1 << 30)) >> 31);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint vector_angle(longint x, longint y);
        longint z, xs, ys, tx;
        z = 0;
        if (x < 0) begin
            tx = y;
            y = -x;
            x = tx;
            z = half_pi_q;
        end
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x += ys; y -= xs; z += atan_tab[i];
            end else begin
                x -= ys; y += xs; z -= atan_tab[i];
            end
        end
        if (z < 0) z = 0;
        if (z > full_pi_q) z = full_pi_q;
        return z;
    endfunction

    function automatic longint rotate_sine(longint phi);
        longint x, y, z, xs, ys;
        x = ONE_Q30;
        y = 0;
        if (phi > half_pi_q) phi = full_pi_q - phi;
        z = phi;
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x -= ys; y += xs; z -= atan_tab[i];
            end else begin
                x += ys; y -= xs; z += atan_tab[i];
            end
        end
        return y;
    endfunction

    function automatic longint clamp_wt(longint k);
        if (k > WT_LIMIT) return WT_LIMIT;
        if (k < -WT_LIMIT) return -WT_LIMIT;
        return k;
    endfunction

    function automatic out_t slerp_predict(in_t it, logic [THR_W-1:0] thr);
        longint a[4], b[4], dot, t, k0, k1, d30, s30, theta, ys, y0, y1, r;
        logic [PATH_W-1:0] path;
        logic [COMP_W-1:0] res[4];
        out_t o;
        a[0] = $signed(it.first_w);  b[0] = $signed(it.second_w);
        a[1] = $signed(it.first_x);  b[1] = $signed(it.second_x);
        a[2] = $signed(it.first_y);  b[2] = $signed(it.second_y);
        a[3] = $signed(it.first_z);  b[3] = $signed(it.second_z);
        dot = 0;
        for (int j = 0; j < 4; j++) dot += a[j] * b[j];
        t = longint'(it.fraction);
        if (t > 65536) t = 65536;
        if (dot == 0) begin
            o.out_w = it.first_w;
            o.out_x = it.first_x;
            o.out_y = it.first_y;
            o.out_z = it.first_z;
            o.path_taken = PATH_PASS;
            return o;
        end
        k0 = 65536 - t;
        k1 = t;
        path = PATH_LINEAR;
        if (dot <= (longint'(thr) <<< FRAC_BITS)) begin
            // Q28 dot to Q30, clamped to the unit range
            d30 = dot * 4;
            if (d30 > ONE_Q30) d30 = ONE_Q30;
            if (d30 < -ONE_Q30) d30 = -ONE_Q30;
            s30 = longint'(int_sqrt(ONE_Q30 * ONE_Q30 - d30 * d30));
            if (s30 != 0) begin
                theta = vector_angle(d30, s30);
                ys = rotate_sine(theta);
                if (ys > 0) begin
                    y0 = rotate_sine((theta * (65536 - t)) >>> 16);
                    y1 = rotate_sine((theta * t) >>> 16);
                    k0 = clamp_wt((y0 * 65536) / ys);
                    k1 = clamp_wt((y1 * 65536) / ys);
                    path = PATH_SPHERE;
                end
            end
        end
        for (int j = 0; j < 4; j++) begin
            r = (k0 * a[j] + k1 * b[j] + 32768) >>> 16;
            if (r > 32767) r = 32767;
            if (r < -32768) r = -32768;
            res[j] = r[15:0];
        end
        o.out_w = res[0];
        o.out_x = res[1];
        o.out_y = res[2];
        o.out_z = res[3];
        o.path_taken = path;
        return o;
    endfunction

    // ---------------- stimulus ----------------

    function automatic logic [COMP_W-1:0] sat16(real v);
        if (v > 32767.0) return 16'h7fff;
        if (v < -32768.0) return 16'h8000;
        return COMP_W'($rtoi(v));
    endfunction

    function automatic logic [FRAC_W-1:0] rand_fraction();
        int sel;
        sel = $urandom_range(99);
        if (sel < 70) return FRAC_W'($urandom_range(65536));
        if (sel < 80) return $urandom_range(1) ? T_ONE : '0;
        return FRAC_W'($urandom_range(131071));
    endfunction

    task automatic queue_item(in_t it);
        pending_items.push_back(it);
        items_queued++;
    endtask

    task automatic queue_quat(int fw, int fx, int fy, int fz, int sw, int sx, int sy, int sz,
                              int frac);
        in_t it;
        it.first_w  = COMP_W'(fw);
        it.first_x  = COMP_W'(fx);
        it.first_y  = COMP_W'(fy);
        it.first_z  = COMP_W'(fz);
        it.second_w = COMP_W'(sw);
        it.second_x = COMP_W'(sx);
        it.second_y = COMP_W'(sy);
        it.second_z = COMP_W'(sz);
        it.fraction = FRAC_W'(frac);
        queue_item(it);
    endtask

    task automatic queue_directed();
        queue_quat(16384, 0, 0, 0, 0, 16384, 0, 0, 32768);        // orthogonal, zero dot
        queue_quat(16384, 0, 0, 0, 16384, 0, 0, 0, 20000);        // identical, linear
        queue_quat(16384, 0, 0, 0, -16384, 0, 0, 0, 32768);       // opposite, degenerate angle
        queue_quat(11585, 11585, 0, 0, 16384, 0, 0, 0, 0);        // 45 degrees, t zero
        queue_quat(11585, 11585, 0, 0, 16384, 0, 0, 0, 65536);    // t one
        queue_quat(11585, 11585, 0, 0, 16384, 0, 0, 0, 131071);   // t saturates
        queue_quat(11585, 0, 11585, 0, -16384, 0, 0, 0, 40000);   // negative dot
        queue_quat(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 30000);
        queue_quat(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, 1);
        queue_quat(32767, -32768, 32767, -32768, -32768, 32767, -32768, 32767, 65535);
        queue_quat(32767, 0, 0, 0, -32768, 0, 0, 0, 16384);       // dot beyond minus one
        queue_quat(16384, 0, 0, 0, 16383, 180, 0, 0, 32768);      // just under one
        queue_quat(0, 0, 0, 0, 12345, -999, 7, 3, 5000);          // zero first
        queue_quat(1, 0, 0, 0, 1, 0, 0, 0, 50000);                // tiny dot, wide angle
        queue_quat(16000, 3000, -2000, 1000, 3000, -16000, 1000, 2000, 12000);
    endtask

    task automatic queue_random(int count);
        real q[4], p[4], n, m;
        in_t it;
        logic [159:0] raw;
        int sel;
        for (int k = 0; k < count; k++) begin
            sel = $urandom_range(99);
            if (sel < 15) begin
                raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
                it = raw[$bits(in_t)-1:0];
                it.fraction = rand_fraction();
            end else begin
                n = 0.0;
                for (int j = 0; j < 4; j++) begin
                    q[j] = real'($urandom_range(65535)) - 32768.0;
                    n += q[j] * q[j];
                end
                n = $sqrt(n) + 1.0;
                m = ($urandom_range(9) == 0) ? real'($urandom_range(32767)) : 16384.0;
                for (int j = 0; j < 4; j++) q[j] = q[j] * m / n;
                sel = $urandom_range(99);
                if (sel < 30) begin
                    // close to the first, around the near threshold
                    for (int j = 0; j < 4; j++)
                        p[j] = q[j] + real'($urandom_range(128)) - 64.0;
                end else if (sel < 40) begin
                    p[0] = -q[1]; p[1] = q[0]; p[2] = -q[3]; p[3] = q[2];
                end else if (sel < 50) begin
                    for (int j = 0; j < 4; j++) p[j] = ($urandom_range(1) ? -q[j] : q[j]);
                end else begin
                    n = 0.0;
                    for (int j = 0; j < 4; j++) begin
                        p[j] = real'($urandom_range(65535)) - 32768.0;
                        n += p[j] * p[j];
                    end
                    n = $sqrt(n) + 1.0;
                    for (int j = 0; j < 4; j++) p[j] = p[j] * 16384.0 / n;
                end
                it.first_w = sat16(q[0]);  it.first_x = sat16(q[1]);
                it.first_y = sat16(q[2]);  it.first_z = sat16(q[3]);
                it.second_w = sat16(p[0]); it.second_x = sat16(p[1]);
                it.second_y = sat16(p[2]); it.second_z = sat16(p[3]);
                it.fraction = rand_fraction();
            end
            queue_item(it);
        end
    endtask

    // ---------------- driver, receiver, monitor ----------------

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            taken_seen <= 0;
        end else begin
            taken_seen <= items_taken;
            if (s_valid && items_taken == taken_seen) begin
                // item still offered, hold it
            end else if (pending_items.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                s_valid <= 1'b1;
                s_data  <= pending_items.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            hold_left <= 0;
            long_hold_done <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!long_hold_done && results_seen >= 500) begin
            // long stall so the pipeline fills and pushes back on the input
            m_ready <= 1'b0;
            hold_left <= LONG_HOLD;
            long_hold_done <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge aclk) begin
        out_t exp_o;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_slerp.push_back(slerp_predict(s_data, thr_model));
                items_taken <= items_taken + 1;
            end
            if (m_valid && m_ready) begin
                results_seen <= results_seen + 1;
                if (expected_slerp.size() == 0) begin
                    $error("result with nothing expected: %h", m_data);
                    mismatches++;
                end else begin
                    exp_o = expected_slerp.pop_front();
                    if (m_data.out_w !== exp_o.out_w) begin
                        $error("out_w expected %0d got %0d", exp_o.out_w, m_data.out_w);
                        mismatches++;
                    end
                    if (m_data.out_x !== exp_o.out_x) begin
                        $error("out_x expected %0d got %0d", exp_o.out_x, m_data.out_x);
                        mismatches++;
                    end
                    if (m_data.out_y !== exp_o.out_y) begin
                        $error("out_y expected %0d got %0d", exp_o.out_y, m_data.out_y);
                        mismatches++;
                    end
                    if (m_data.out_z !== exp_o.out_z) begin
                        $error("out_z expected %0d got %0d", exp_o.out_z, m_data.out_z);
                        mismatches++;
                    end
                    if (m_data.path_taken !== exp_o.path_taken) begin
                        $error("path_taken expected %0d got %0d",
                               exp_o.path_taken, m_data.path_taken);
                        mismatches++;
                    end
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // ---------------- sequencing ----------------

    initial begin
        logic [THR_W-1:0] thr_list[NUM_PHASES];
        thr_list = '{THR_RESET, 15'd0, 15'd16384, 15'd32767, 15'd12000};
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        thr_model = THR_RESET;
        items_queued = 0;
        items_taken = 0;
        results_seen = 0;
        mismatches = 0;
        quiet_cycles = 0;
        src_idle_pct = 34;
        snk_idle_pct = 80;
        build_angles();
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            src_idle_pct = (ph < 2) ? 34 : (ph < 4) ? 80 : 0;
            snk_idle_pct = (ph < 2) ? 80 : (ph < 4) ? 34 : 0;
            if (ph > 0) begin
                @(negedge aclk);
                cfg_wr_en <= 1'b1;
                cfg_wr_data <= thr_list[ph];
                thr_model = thr_list[ph];
                @(negedge aclk);
                cfg_wr_en <= 1'b0;
            end
            if (ph == 0) queue_directed();
            queue_random(ITEMS_PER_PHASE - (ph == 0 ? 15 : 0));
            while (items_taken != items_queued || expected_slerp.size() != 0)
                @(posedge aclk);
            repeat (DRAIN_CYCLES) @(posedge aclk);
        end
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/qslerp_pkg.sv
rtl/qslerp_isqrt.sv
rtl/qslerp_cordic_vec.sv
rtl/qslerp_cordic_rot.sv
rtl/qslerp_div.sv
rtl/quaternion_slerp.sv
sim/quaternion_slerp_tb.sv
